[hdl/lrmp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the linear recurrence term engine.
// No dependencies; every other file in hdl/ refers to this package by scoped name.

package lrmp_pkg;

	localparam int VAL_W   = 30;
	localparam int INDEX_W = 64;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int PROD_W  = 3;

	typedef logic [VAL_W-1:0]      lrmp_val_t;
	typedef logic [3:0][VAL_W-1:0] lrmp_mat_t;

	localparam lrmp_val_t PRIME = 30'd998244353;
	localparam logic [31:0] PRIME_X2 = 32'd1996488706;

	// Barrett constant floor(2^60 / PRIME), needs 31 bits
	localparam logic [63:0] MU_WIDE    = (64'd1 << 60) / 64'd998244353;
	localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

	localparam lrmp_val_t RST_COEF_PREV      = 30'd8;
	localparam lrmp_val_t RST_COEF_PREV_PREV = 30'd998244349;
	localparam lrmp_val_t RST_TERM_ONE       = 30'd6;
	localparam lrmp_val_t RST_TERM_ZERO      = 30'd1;

	// index of the last product of a 2x2 matrix product, and of the final dot product
	localparam logic [PROD_W-1:0] LAST_MAT_PROD = 3'd7;
	localparam logic [PROD_W-1:0] LAST_FIN_PROD = 3'd1;

	typedef enum logic [1:0] {
		REG_COEF_PREV      = 2'd0,
		REG_COEF_PREV_PREV = 2'd1,
		REG_TERM_ONE       = 2'd2,
		REG_TERM_ZERO      = 2'd3
	} lrmp_reg_t;

	typedef enum logic [1:0] {
		OP_ACC_BASE,
		OP_BASE_SQ,
		OP_FINAL
	} lrmp_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_AB_ISSUE,
		ST_AB_DRAIN,
		ST_SQ_ISSUE,
		ST_SQ_DRAIN,
		ST_FIN_ISSUE,
		ST_FIN_DRAIN
	} lrmp_state_t;

	typedef struct packed {
		lrmp_val_t coef_prev;
		lrmp_val_t coef_prev_prev;
		lrmp_val_t term_one;
		lrmp_val_t term_zero;
	} lrmp_cfg_t;

	typedef struct packed {
		logic              load;
		logic              issue;
		lrmp_op_t          op;
		logic [PROD_W-1:0] prod;
		logic              commit_acc;
		logic              commit_base;
		logic              shift;
		logic              out_load;
	} lrmp_cmd_t;

	typedef struct packed {
		logic e_zero;
		logic e_one;
		logic e_lsb;
		logic busy;
	} lrmp_stat_t;

endpackage

[hdl/lrmp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the index request and the term result.
// Depends on lrmp_pkg for field widths.

interface lrmp_index_if;
	logic                             valid;
	logic                             ready;
	logic [lrmp_pkg::INDEX_W-1:0]     index;

	modport source (output valid, output index, input ready);
	modport sink   (input valid, input index, output ready);
endinterface

interface lrmp_term_if;
	logic                valid;
	logic                ready;
	lrmp_pkg::lrmp_val_t term_value;

	modport source (output valid, output term_value, input ready);
	modport sink   (input valid, input term_value, output ready);
endinterface

[hdl/lrmp_modmul.sv]
`timescale 1ns / 1ps
// Five-stage modular multiplier: 30x30 product, Barrett reduction by the fixed prime.
// Depends on lrmp_pkg. Accepts one product per cycle and carries a tag alongside.

module lrmp_modmul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  lrmp_pkg::lrmp_val_t             a,
	input  lrmp_pkg::lrmp_val_t             b,
	input  logic [lrmp_pkg::PROD_W-1:0]     tag,
	output logic                            res_valid,
	output lrmp_pkg::lrmp_val_t             res,
	output logic [lrmp_pkg::PROD_W-1:0]     res_tag,
	output logic                            busy
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [lrmp_pkg::PROD_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [59:0] prod_s1;
	logic [30:0] quot_s2;
	logic [31:0] xlo_s2, xlo_s3;
	logic [31:0] qp_s3;
	logic [31:0] rem_s4;
	lrmp_pkg::lrmp_val_t res_s5;

	logic [61:0] quot_full;
	logic [60:0] qp_full;
	logic [31:0] rem_fix;

	assign quot_full = 62'(prod_s1[59:29]) * 62'(lrmp_pkg::BARRETT_MU);
	assign qp_full   = 61'(quot_s2) * 61'(lrmp_pkg::PRIME);

	// Barrett leaves the remainder below three times the prime
	always_comb begin
		priority if (rem_s4 >= lrmp_pkg::PRIME_X2) begin
			rem_fix = rem_s4 - lrmp_pkg::PRIME_X2;
		end else if (rem_s4 >= 32'(lrmp_pkg::PRIME)) begin
			rem_fix = rem_s4 - 32'(lrmp_pkg::PRIME);
		end else begin
			rem_fix = rem_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 60'(a) * 60'(b);
		tag_s1  <= tag;
		quot_s2 <= quot_full[61:31];
		xlo_s2  <= prod_s1[31:0];
		tag_s2  <= tag_s1;
		qp_s3   <= qp_full[31:0];
		xlo_s3  <= xlo_s2;
		tag_s3  <= tag_s2;
		// only the low 32 bits matter: the true difference is below 2^32
		rem_s4  <= xlo_s3 - qp_s3;
		tag_s4  <= tag_s3;
		res_s5  <= rem_fix[lrmp_pkg::VAL_W-1:0];
		tag_s5  <= tag_s4;
	end

	assign res_valid = v_s5;
	assign res       = res_s5;
	assign res_tag   = tag_s5;
	assign busy      = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

endmodule

[hdl/lrmp_datapath.sv]
`timescale 1ns / 1ps
// Datapath: accumulator and base matrices, exponent register, product scratch and result.
// Depends on lrmp_pkg and lrmp_modmul; driven by lrmp_ctrl through lrmp_cmd_t.

module lrmp_datapath #(
	parameter int INDEX_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [lrmp_pkg::INDEX_W-1:0]    index,
	input  lrmp_pkg::lrmp_cfg_t             cfg,
	input  lrmp_pkg::lrmp_cmd_t             cmd,
	output lrmp_pkg::lrmp_stat_t            stat,
	output lrmp_pkg::lrmp_val_t             term_value
);

	function automatic lrmp_pkg::lrmp_val_t reduce(input lrmp_pkg::lrmp_val_t v);
		return (v >= lrmp_pkg::PRIME) ? lrmp_pkg::lrmp_val_t'(v - lrmp_pkg::PRIME) : v;
	endfunction

	function automatic lrmp_pkg::lrmp_val_t add_mod(input lrmp_pkg::lrmp_val_t x,
			input lrmp_pkg::lrmp_val_t y);
		logic [lrmp_pkg::VAL_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s >= {1'b0, lrmp_pkg::PRIME}) ?
			lrmp_pkg::lrmp_val_t'(s - {1'b0, lrmp_pkg::PRIME}) : s[lrmp_pkg::VAL_W-1:0];
	endfunction

	lrmp_pkg::lrmp_mat_t acc_q, base_q, prod_q;
	lrmp_pkg::lrmp_val_t term_one_q, term_zero_q, partial_q, out_q;
	logic [INDEX_BITS-1:0] exp_q;
	logic [INDEX_BITS-1:0] n;

	lrmp_pkg::lrmp_val_t opa, opb;
	logic [1:0] row_sel, col_sel;
	logic mm_valid, mm_busy;
	lrmp_pkg::lrmp_val_t mm_res;
	logic [lrmp_pkg::PROD_W-1:0] mm_tag;

	assign n = index[INDEX_BITS-1:0];

	// product k of X*Y: entry {i,j} = k[2:1], inner term m = k[0]; X[i][m] * Y[m][j]
	assign row_sel = {cmd.prod[2], cmd.prod[0]};
	assign col_sel = {cmd.prod[0], cmd.prod[1]};

	always_comb begin
		unique case (cmd.op)
			lrmp_pkg::OP_ACC_BASE: begin
				opa = acc_q[row_sel];
				opb = base_q[col_sel];
			end
			lrmp_pkg::OP_BASE_SQ: begin
				opa = base_q[row_sel];
				opb = base_q[col_sel];
			end
			lrmp_pkg::OP_FINAL: begin
				opa = acc_q[{1'b0, cmd.prod[0]}];
				opb = cmd.prod[0] ? term_zero_q : term_one_q;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	lrmp_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.issue),
		.a         (opa),
		.b         (opb),
		.tag       (cmd.prod),
		.res_valid (mm_valid),
		.res       (mm_res),
		.res_tag   (mm_tag),
		.busy      (mm_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// index zero picks term_zero through the final dot product
			if (n == '0) begin
				acc_q <= {lrmp_pkg::VAL_W'(0), lrmp_pkg::VAL_W'(0),
					lrmp_pkg::VAL_W'(1), lrmp_pkg::VAL_W'(0)};
				exp_q <= '0;
			end else begin
				acc_q <= {lrmp_pkg::VAL_W'(1), lrmp_pkg::VAL_W'(0),
					lrmp_pkg::VAL_W'(0), lrmp_pkg::VAL_W'(1)};
				exp_q <= n - INDEX_BITS'(1);
			end
			base_q <= {lrmp_pkg::VAL_W'(0), lrmp_pkg::VAL_W'(1),
				reduce(cfg.coef_prev_prev), reduce(cfg.coef_prev)};
			term_one_q  <= reduce(cfg.term_one);
			term_zero_q <= reduce(cfg.term_zero);
		end else begin
			if (cmd.commit_acc) begin
				acc_q <= prod_q;
			end
			if (cmd.commit_base) begin
				base_q <= prod_q;
			end
			if (cmd.shift) begin
				exp_q <= exp_q >> 1;
			end
		end
		// even tag opens an entry, odd tag closes it
		if (mm_valid) begin
			if (!mm_tag[0]) begin
				partial_q <= mm_res;
			end else begin
				prod_q[mm_tag[2:1]] <= add_mod(partial_q, mm_res);
			end
		end
		if (cmd.out_load) begin
			out_q <= prod_q[0];
		end
	end

	assign stat.e_zero = (exp_q == '0);
	assign stat.e_one  = (exp_q == INDEX_BITS'(1));
	assign stat.e_lsb  = exp_q[0];
	assign stat.busy   = mm_busy;
	assign term_value  = out_q;

endmodule

[hdl/lrmp_ctrl.sv]
`timescale 1ns / 1ps
// Controller: walks the exponent bits, issues matrix products and hands off the result.
// Depends on lrmp_pkg; talks to lrmp_datapath through lrmp_cmd_t and lrmp_stat_t.

module lrmp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lrmp_pkg::lrmp_stat_t stat,
	output lrmp_pkg::lrmp_cmd_t  cmd
);

	lrmp_pkg::lrmp_state_t state_q, state_d;
	logic [lrmp_pkg::PROD_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrmp_pkg::ST_IDLE: begin
				if (in_valid) state_d = lrmp_pkg::ST_CHECK;
			end
			lrmp_pkg::ST_CHECK: begin
				priority if (stat.e_zero) state_d = lrmp_pkg::ST_FIN_ISSUE;
				else if (stat.e_lsb) state_d = lrmp_pkg::ST_AB_ISSUE;
				else state_d = lrmp_pkg::ST_SQ_ISSUE;
			end
			lrmp_pkg::ST_AB_ISSUE: begin
				if (cnt_q == lrmp_pkg::LAST_MAT_PROD) state_d = lrmp_pkg::ST_AB_DRAIN;
			end
			lrmp_pkg::ST_AB_DRAIN: begin
				// last exponent bit: the square would go unused
				if (!stat.busy) begin
					state_d = stat.e_one ? lrmp_pkg::ST_CHECK : lrmp_pkg::ST_SQ_ISSUE;
				end
			end
			lrmp_pkg::ST_SQ_ISSUE: begin
				if (cnt_q == lrmp_pkg::LAST_MAT_PROD) state_d = lrmp_pkg::ST_SQ_DRAIN;
			end
			lrmp_pkg::ST_SQ_DRAIN: begin
				if (!stat.busy) state_d = lrmp_pkg::ST_CHECK;
			end
			lrmp_pkg::ST_FIN_ISSUE: begin
				if (cnt_q == lrmp_pkg::LAST_FIN_PROD) state_d = lrmp_pkg::ST_FIN_DRAIN;
			end
			lrmp_pkg::ST_FIN_DRAIN: begin
				if (!stat.busy && out_free) state_d = lrmp_pkg::ST_IDLE;
			end
			default: state_d = lrmp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = lrmp_pkg::OP_ACC_BASE;
		cmd.prod = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			lrmp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lrmp_pkg::ST_CHECK: begin
			end
			lrmp_pkg::ST_AB_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.op    = lrmp_pkg::OP_ACC_BASE;
			end
			lrmp_pkg::ST_AB_DRAIN: begin
				if (!stat.busy) begin
					cmd.commit_acc = 1'b1;
					cmd.shift      = stat.e_one;
				end
			end
			lrmp_pkg::ST_SQ_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.op    = lrmp_pkg::OP_BASE_SQ;
			end
			lrmp_pkg::ST_SQ_DRAIN: begin
				if (!stat.busy) begin
					cmd.commit_base = 1'b1;
					cmd.shift       = 1'b1;
				end
			end
			lrmp_pkg::ST_FIN_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.op    = lrmp_pkg::OP_FINAL;
			end
			lrmp_pkg::ST_FIN_DRAIN: begin
				cmd.out_load = !stat.busy && out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrmp_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// wraps to zero after the last product of a matrix
			cnt_q   <= cmd.issue ? cnt_q + 1'b1 : '0;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/linear_recurrence_mod_power.sv]
`timescale 1ns / 1ps
// Returns term n of a(n) = coef_prev*a(n-1) + coef_prev_prev*a(n-2) modulo 998244353,
// by square-and-multiply of the 2x2 companion matrix over the low INDEX_BITS bits of
// the index. One index is worked on at a time; its result waits in an output register
// so the next index can be taken before the result is collected. Indexes zero and one
// go straight to the final dot product. An index n >= 2 takes one matrix product for
// every bit of n-1 and one more for every set bit below the top one, then the final
// dot product; a result not yet collected holds the next index back before its own
// result is loaded. Matrix and dot products run on the single shared five-stage
// modular multiplier, which takes one product a cycle: eight per matrix product, then
// a drain of its pipeline before the matrix is committed. Configuration registers
// (APB, byte address 4*i) are to be written only while the block is idle; the block
// itself does not enforce this.

module linear_recurrence_mod_power #(
	parameter int INDEX_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lrmp_pkg::PADDR_W-1:0]   paddr,
	input  logic [lrmp_pkg::PDATA_W-1:0]   pwdata,
	output logic [lrmp_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	lrmp_index_if.sink                     index_chan,
	lrmp_term_if.source                    term_chan
);

	lrmp_pkg::lrmp_cfg_t  cfg_q;
	lrmp_pkg::lrmp_cmd_t  cmd;
	lrmp_pkg::lrmp_stat_t stat;
	lrmp_pkg::lrmp_reg_t  reg_sel;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = lrmp_pkg::lrmp_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_prev      <= lrmp_pkg::RST_COEF_PREV;
			cfg_q.coef_prev_prev <= lrmp_pkg::RST_COEF_PREV_PREV;
			cfg_q.term_one       <= lrmp_pkg::RST_TERM_ONE;
			cfg_q.term_zero      <= lrmp_pkg::RST_TERM_ZERO;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				lrmp_pkg::REG_COEF_PREV:
					cfg_q.coef_prev <= pwdata[lrmp_pkg::VAL_W-1:0];
				lrmp_pkg::REG_COEF_PREV_PREV:
					cfg_q.coef_prev_prev <= pwdata[lrmp_pkg::VAL_W-1:0];
				lrmp_pkg::REG_TERM_ONE:
					cfg_q.term_one <= pwdata[lrmp_pkg::VAL_W-1:0];
				lrmp_pkg::REG_TERM_ZERO:
					cfg_q.term_zero <= pwdata[lrmp_pkg::VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			lrmp_pkg::REG_COEF_PREV:      prdata = lrmp_pkg::PDATA_W'(cfg_q.coef_prev);
			lrmp_pkg::REG_COEF_PREV_PREV: prdata = lrmp_pkg::PDATA_W'(cfg_q.coef_prev_prev);
			lrmp_pkg::REG_TERM_ONE:       prdata = lrmp_pkg::PDATA_W'(cfg_q.term_one);
			lrmp_pkg::REG_TERM_ZERO:      prdata = lrmp_pkg::PDATA_W'(cfg_q.term_zero);
			default:                      prdata = '0;
		endcase
	end

	lrmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (index_chan.valid),
		.in_ready  (index_chan.ready),
		.out_valid (term_chan.valid),
		.out_ready (term_chan.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lrmp_datapath #(
		.INDEX_BITS (INDEX_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.index      (index_chan.index),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.stat       (stat),
		.term_value (term_chan.term_value)
	);

endmodule
